// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is held
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check, also active during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/cbpg_pkg.sv -----
// ----------------------------------------------------------------------------
// cbpg_pkg
// Widths and types shared by the Bezier point generator and its channels.
// ----------------------------------------------------------------------------
package cbpg_pkg;

  localparam int COORD_W    = 16;  // Q12.4 coordinate
  localparam int CNT_W      = 6;   // segment count
  localparam int Q_FRAC     = 16;  // Q0.16 parameter t
  localparam int T_W        = 16;
  localparam int COEF_W     = 21;  // power basis coefficients
  localparam int PROD_W     = 38;  // coef x t product
  localparam int ACC_W      = 40;  // curve sum, units of 2^-20
  localparam int QUO_W      = Q_FRAC + 1;
  localparam int DIV_CNT_W  = 5;

  localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic        [T_W-1:0]     tfrac_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

// ----- rtl/cbpg_in_if.sv -----
// ----------------------------------------------------------------------------
// cbpg_in_if
// Curve word channel: four control points and a segment count.
// ----------------------------------------------------------------------------
interface cbpg_in_if import cbpg_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  coord_t ctrl_one_x;
  coord_t ctrl_one_y;
  coord_t ctrl_two_x;
  coord_t ctrl_two_y;
  cnt_t   segment_count;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
           ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y, segment_count,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
           ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y, segment_count,
    output ready
  );

endinterface

// ----- rtl/cbpg_out_if.sv -----
// ----------------------------------------------------------------------------
// cbpg_out_if
// Point word channel: one curve point and an end-of-run flag.
// ----------------------------------------------------------------------------
interface cbpg_out_if import cbpg_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (
    output valid, point_x, point_y, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, last_point,
    output ready
  );

endinterface

// ----- rtl/cubic_bezier_point_generator.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// Cubic Bezier curve evaluation on one shared multiplier.
// ----------------------------------------------------------------------------
// One curve word yields N+1 point words (N = segment_count, clipped to
// MAX_SEGMENTS): the start point, N-1 interior points at t = i/N evaluated
// in power basis with Q0.16 t and rounded, saturated Q12.4 output, then the
// end point flagged with last_point. N = 0 yields nothing. The step 1/N is
// found once per curve by a shift-subtract divider; each interior point is
// then built from eight multiplies (t^2, t^3 and three per axis), each
// passing through the S_MUL and S_ACC states, on a single 21x17 multiplier.
// A curve holds the input channel from acceptance until its end point is
// loaded into the output register; the input is taken again while the end
// point still waits in the output register.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator import cbpg_pkg::*; #(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic clk,
  input  logic rst_n,
  cbpg_in_if.sink    in_bus,
  cbpg_out_if.source out_bus
);

  `include "assert_macros.svh"

  localparam cnt_t MAX_CNT = CNT_W'(MAX_SEGMENTS);
  localparam int   HALF    = 1 << (Q_FRAC - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  localparam logic [2:0] OP_TT = 3'd0;
  localparam logic [2:0] OP_T3 = 3'd1;
  localparam logic [2:0] OP_AX = 3'd2;
  localparam logic [2:0] OP_BX = 3'd3;
  localparam logic [2:0] OP_CX = 3'd4;
  localparam logic [2:0] OP_AY = 3'd5;
  localparam logic [2:0] OP_BY = 3'd6;
  localparam logic [2:0] OP_CY = 3'd7;

  function automatic coef_t coef_a(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    coef_t d;
    d = COEF_W'(p1) - COEF_W'(p2);
    return COEF_W'(p3) + d + (d <<< 1) - COEF_W'(p0);
  endfunction

  function automatic coef_t coef_b(coord_t p0, coord_t p1, coord_t p2);
    coef_t e;
    e = COEF_W'(p0) - (COEF_W'(p1) <<< 1) + COEF_W'(p2);
    return e + (e <<< 1);
  endfunction

  function automatic coef_t coef_c(coord_t p0, coord_t p1);
    coef_t d;
    d = COEF_W'(p1) - COEF_W'(p0);
    return d + (d <<< 1);
  endfunction

  function automatic coord_t round_sat(acc_t v);
    acc_t s;
    acc_t sh;
    s  = v + ACC_W'(HALF);
    sh = s >>> Q_FRAC;
    if (&sh[ACC_W-1:COORD_W-1] || ~|sh[ACC_W-1:COORD_W-1]) begin
      return sh[COORD_W-1:0];
    end
    return sh[ACC_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  logic [2:0]           state_r, state_nxt;
  coord_t               p0x_r, p0y_r, p3x_r, p3y_r;
  coef_t                ax_r, bx_r, cx_r, ay_r, by_r, cy_r;
  cnt_t                 n_r, i_r, frac_r, r0_r, rem_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  tfrac_t               t_r, t2_r, t3_r;
  logic [2:0]           op_r;
  prod_t                prod_r;
  acc_t                 acc_r;
  coord_t               rx_r, ry_r;
  logic                 out_valid_r;
  coord_t               out_x_r, out_y_r;
  logic                 out_last_r;

  logic             in_acc, out_free;
  cnt_t             seg_sat;
  logic [CNT_W:0]   rem_sh, fsum;
  logic             div_ge, fge;
  cnt_t             rem_new, frac_new;
  tfrac_t           t_new, t_rnd;
  logic [2*T_W:0]   tq;
  coef_t            mul_a;
  tfrac_t           mul_b;
  prod_t            prod_nxt;
  acc_t             acc_base, acc_sum;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign seg_sat      = (in_bus.segment_count > MAX_CNT) ? MAX_CNT : in_bus.segment_count;

  // reciprocal step 2^16 / N, one quotient bit per cycle
  assign rem_sh  = {rem_r, (div_cnt_r == DIV_CNT_W'(Q_FRAC))};
  assign div_ge  = rem_sh >= {1'b0, n_r};
  assign rem_new = div_ge ? CNT_W'(rem_sh - {1'b0, n_r}) : rem_sh[CNT_W-1:0];

  // t advance with remainder carry
  assign fsum     = {1'b0, frac_r} + {1'b0, r0_r};
  assign fge      = fsum >= {1'b0, n_r};
  assign frac_new = fge ? CNT_W'(fsum - {1'b0, n_r}) : fsum[CNT_W-1:0];
  assign t_new    = T_W'(t_r + quo_r[T_W-1:0] + T_W'(fge));

  always_comb begin
    mul_a = ax_r;
    mul_b = t3_r;
    unique case (op_r)
      OP_TT: begin
        mul_a = COEF_W'({1'b0, t_r});
        mul_b = t_r;
      end
      OP_T3: begin
        mul_a = COEF_W'({1'b0, t2_r});
        mul_b = t_r;
      end
      OP_AX: begin
        mul_a = ax_r;
        mul_b = t3_r;
      end
      OP_BX: begin
        mul_a = bx_r;
        mul_b = t2_r;
      end
      OP_CX: begin
        mul_a = cx_r;
        mul_b = t_r;
      end
      OP_AY: begin
        mul_a = ay_r;
        mul_b = t3_r;
      end
      OP_BY: begin
        mul_a = by_r;
        mul_b = t2_r;
      end
      OP_CY: begin
        mul_a = cy_r;
        mul_b = t_r;
      end
      default: begin
        mul_a = ax_r;
        mul_b = t3_r;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

  assign tq    = prod_r[2*T_W:0] + (2*T_W+1)'(HALF);
  assign t_rnd = tq[2*T_W-1:T_W];

  assign acc_base = (op_r == OP_AX) ? (ACC_W'(p0x_r) <<< Q_FRAC) :
                    (op_r == OP_AY) ? (ACC_W'(p0y_r) <<< Q_FRAC) : acc_r;
  assign acc_sum  = acc_base + ACC_W'(prod_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && seg_sat != '0) state_nxt = S_START;
      S_START: if (out_free) state_nxt = (n_r == CNT_W'(1)) ? S_END : S_DIV;
      S_DIV:   if (div_cnt_r == '0) state_nxt = S_STEP;
      S_STEP:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = (op_r == OP_CY) ? S_EMIT : S_MUL;
      S_EMIT:  if (out_free) state_nxt = (i_r == n_r - CNT_W'(1)) ? S_END : S_STEP;
      S_END:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p0x_r <= in_bus.start_x;
      p0y_r <= in_bus.start_y;
      p3x_r <= in_bus.end_x;
      p3y_r <= in_bus.end_y;
      ax_r  <= coef_a(in_bus.start_x, in_bus.ctrl_one_x, in_bus.ctrl_two_x, in_bus.end_x);
      ay_r  <= coef_a(in_bus.start_y, in_bus.ctrl_one_y, in_bus.ctrl_two_y, in_bus.end_y);
      bx_r  <= coef_b(in_bus.start_x, in_bus.ctrl_one_x, in_bus.ctrl_two_x);
      by_r  <= coef_b(in_bus.start_y, in_bus.ctrl_one_y, in_bus.ctrl_two_y);
      cx_r  <= coef_c(in_bus.start_x, in_bus.ctrl_one_x);
      cy_r  <= coef_c(in_bus.start_y, in_bus.ctrl_one_y);
      n_r   <= seg_sat;
    end
    unique case (state_r)
      S_START: begin
        rem_r     <= '0;
        quo_r     <= '0;
        div_cnt_r <= DIV_CNT_W'(Q_FRAC);
        i_r       <= CNT_W'(1);
      end
      S_DIV: begin
        rem_r     <= rem_new;
        quo_r     <= {quo_r[QUO_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == '0) begin
          r0_r   <= rem_new;
          t_r    <= '0;
          frac_r <= n_r >> 1;
        end
      end
      S_STEP: begin
        t_r    <= t_new;
        frac_r <= frac_new;
        op_r   <= OP_TT;
      end
      S_MUL: begin
        prod_r <= prod_nxt;
      end
      S_ACC: begin
        case (op_r)
          OP_TT:   t2_r <= t_rnd;
          OP_T3:   t3_r <= t_rnd;
          default: acc_r <= acc_sum;
        endcase
        if (op_r == OP_CX) rx_r <= round_sat(acc_sum);
        if (op_r == OP_CY) ry_r <= round_sat(acc_sum);
        op_r <= op_r + 3'd1;
      end
      S_EMIT: begin
        if (out_free) i_r <= i_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free && (state_r == S_START || state_r == S_EMIT ||
                              state_r == S_END)) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      unique case (state_r)
        S_START: begin
          out_x_r    <= p0x_r;
          out_y_r    <= p0y_r;
          out_last_r <= 1'b0;
        end
        S_EMIT: begin
          out_x_r    <= rx_r;
          out_y_r    <= ry_r;
          out_last_r <= 1'b0;
        end
        S_END: begin
          out_x_r    <= p3x_r;
          out_y_r    <= p3y_r;
          out_last_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.point_x    = out_x_r;
  assign out_bus.point_y    = out_y_r;
  assign out_bus.last_point = out_last_r;

  `ASSERT_CLK(a_end_flags_last, clk, rst_n, (state_r == S_END && out_free) |=> (state_r == S_IDLE && out_valid_r && out_last_r), "end point not flagged as last word")
  `ASSERT_CLK(a_frac_in_range, clk, rst_n, (state_r == S_STEP) |-> (frac_r < n_r), "t remainder out of range")
  `ASSERT_CLK(a_zero_count_idle, clk, rst_n, (in_acc && in_bus.segment_count == '0) |=> (state_r == S_IDLE), "zero segment count left idle")
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid_r && state_r == S_IDLE), "reset did not clear control state")

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cubic_bezier_point_generator. Curve words go in
// from a directed table, then from a random mix that favors short runs.
// A local fixed-point predictor queues the point words each curve should
// produce, and every point word taken from the block is compared against
// them in order. Both channels idle at random, and the point side once
// holds off for a long stretch so the curve side backs up.
// ----------------------------------------------------------------------------
module tb;
  import cbpg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SEG    = 63;
  localparam int N_RANDOM   = 200;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_CYC  = 60;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
    coord_t ex;
    coord_t ey;
    cnt_t   n;
  } curve_t;

  typedef struct packed {
    logic   typed;
    curve_t cv;
    coord_t mx;
    coord_t my;
  } curve_row_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  logic clk;
  logic rst_n;

  cbpg_in_if  in_bus ();
  cbpg_out_if out_bus ();

  cubic_bezier_point_generator #(
    .MAX_SEGMENTS (MAX_SEG)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  point_t points_due[$];
  int     n_curves;
  int     n_points;
  int     n_errors;
  bit     gaps_on;

  // typed rows: start point, N-1 interior points at (mx, my), then end point
  localparam int N_DIR = 18;
  curve_row_t curve_table [N_DIR] = '{
    '{1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 6'd0},
      16'sd0, 16'sd0},
    '{1'b1, '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MAX, COORD_MAX, 6'd0}, 16'sd0, 16'sd0},
    '{1'b1, '{16'sd100, -16'sd200, 16'sd5000, 16'sd77, -16'sd9000, 16'sd31,
              -16'sd300, 16'sd400, 6'd1}, 16'sd0, 16'sd0},
    '{1'b1, '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
              COORD_MAX, COORD_MIN, 6'd1}, 16'sd0, 16'sd0},
    '{1'b1, '{16'sd1234, -16'sd567, 16'sd1234, -16'sd567, 16'sd1234, -16'sd567,
              16'sd1234, -16'sd567, 6'd5}, 16'sd1234, -16'sd567},
    '{1'b1, '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MAX, COORD_MAX, 6'd63}, COORD_MAX, COORD_MAX},
    '{1'b1, '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MIN, COORD_MIN, 6'd7}, COORD_MIN, COORD_MIN},
    '{1'b0, '{16'sd0, 16'sd0, 16'sd160, 16'sd80, 16'sd320, 16'sd160,
              16'sd480, 16'sd240, 6'd2}, 16'sd0, 16'sd0},
    '{1'b0, '{-16'sd1200, 16'sd3400, 16'sd22000, -16'sd15000, -16'sd7000, 16'sd29000,
              16'sd8000, -16'sd4000, 6'd63}, 16'sd0, 16'sd0},
    '{1'b0, '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MIN, COORD_MIN, 6'd4}, 16'sd0, 16'sd0},
    '{1'b0, '{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MAX, COORD_MAX, 6'd3}, 16'sd0, 16'sd0},
    '{1'b0, '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
              COORD_MAX, COORD_MIN, 6'd16}, 16'sd0, 16'sd0},
    '{1'b0, '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
              COORD_MIN, COORD_MAX, 6'd63}, 16'sd0, 16'sd0},
    '{1'b0, '{16'sd3, -16'sd7, 16'sd11, 16'sd2, -16'sd5, 16'sd9,
              16'sd1, -16'sd1, 6'd3}, 16'sd0, 16'sd0},
    '{1'b0, '{16'sd17000, -16'sd250, -16'sd32000, 16'sd32000, 16'sd32000, -16'sd32000,
              -16'sd17000, 16'sd250, 6'd62}, 16'sd0, 16'sd0},
    '{1'b1, '{16'sd42, -16'sd42, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
              -16'sd1, 16'sd1, 6'd1}, 16'sd0, 16'sd0},
    '{1'b0, '{-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1,
              16'sd1, 16'sd1, 6'd10}, 16'sd0, 16'sd0},
    '{1'b0, '{16'sd2047, -16'sd2048, -16'sd6000, 16'sd6000, 16'sd9000, 16'sd100,
              16'sd0, COORD_MAX, 6'd33}, 16'sd0, 16'sd0}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void queue_point(coord_t px, coord_t py, logic plast);
    point_t pt;
    pt.x       = px;
    pt.y       = py;
    pt.last    = plast;
    points_due = {points_due, pt};
  endfunction

  function automatic coord_t curve_coord(longint p0, longint p1, longint p2, longint p3,
                                         longint t1, longint t2, longint t3);
    longint ca, cb, cc, acc, r;
    ca  = p3 + 3 * (p1 - p2) - p0;
    cb  = 3 * (p0 - 2 * p1 + p2);
    cc  = 3 * (p1 - p0);
    acc = ca * t3 + cb * t2 + cc * t1 + p0 * 65536;
    r   = (acc + 32768) >>> 16;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return coord_t'(r);
  endfunction

  task automatic predict_curve_points(input curve_t cv);
    longint segs, t1, t2, t3;
    segs = cv.n;
    if (segs > MAX_SEG) segs = MAX_SEG;
    if (segs == 0) return;
    queue_point(cv.sx, cv.sy, 1'b0);
    for (longint i = 1; i < segs; i++) begin
      t1 = ((i << 16) + segs / 2) / segs;
      t2 = (t1 * t1 + 32768) >> 16;
      t3 = (t2 * t1 + 32768) >> 16;
      queue_point(curve_coord(cv.sx, cv.c1x, cv.c2x, cv.ex, t1, t2, t3),
                  curve_coord(cv.sy, cv.c1y, cv.c2y, cv.ey, t1, t2, t3),
                  1'b0);
    end
    queue_point(cv.ex, cv.ey, 1'b1);
  endtask

  task automatic offer_curve(input curve_t cv);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.start_x       <= cv.sx;
    in_bus.start_y       <= cv.sy;
    in_bus.ctrl_one_x    <= cv.c1x;
    in_bus.ctrl_one_y    <= cv.c1y;
    in_bus.ctrl_two_x    <= cv.c2x;
    in_bus.ctrl_two_y    <= cv.c2y;
    in_bus.end_x         <= cv.ex;
    in_bus.end_y         <= cv.ey;
    in_bus.segment_count <= cv.n;
    do @(posedge clk); while (!in_bus.ready);
    n_curves++;
  endtask

  function automatic coord_t rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return coord_t'($urandom_range(0, 200) - 100);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic cnt_t rand_count();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return cnt_t'(MAX_SEG);
      1, 2: return cnt_t'($urandom_range(0, 63));
      default: return cnt_t'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic check_point(input coord_t px, input coord_t py, input logic plast);
    point_t due;
    if (points_due.size() == 0) begin
      $display("%0t: point word with nothing expected: x %0d y %0d last %0b",
               $time, px, py, plast);
      n_errors++;
      return;
    end
    due = points_due.pop_front();
    if (px !== due.x) begin
      $display("%0t: point %0d x expected %0d got %0d", $time, n_points, due.x, px);
      n_errors++;
    end
    if (py !== due.y) begin
      $display("%0t: point %0d y expected %0d got %0d", $time, n_points, due.y, py);
      n_errors++;
    end
    if (plast !== due.last) begin
      $display("%0t: point %0d last expected %0b got %0b", $time, n_points, due.last,
               plast);
      n_errors++;
    end
    n_points++;
  endtask

  initial begin : point_sink
    int  hold;
    bit  held_long;
    held_long = 1'b0;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = gaps_on ? $urandom_range(0, 7) : 0;
      // one long back-pressure stretch so the curve side stalls
      if (!held_long && n_points >= 60) begin
        hold      = LONG_HOLD;
        held_long = 1'b1;
      end
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      check_point(out_bus.point_x, out_bus.point_y, out_bus.last_point);
    end
  end

  initial begin : curve_source
    curve_t     cv;
    curve_row_t row;
    clk                  = 1'b0;
    n_curves             = 0;
    n_points             = 0;
    n_errors             = 0;
    gaps_on              = 1'b1;
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.start_x       <= '0;
    in_bus.start_y       <= '0;
    in_bus.ctrl_one_x    <= '0;
    in_bus.ctrl_one_y    <= '0;
    in_bus.ctrl_two_x    <= '0;
    in_bus.ctrl_two_y    <= '0;
    in_bus.end_x         <= '0;
    in_bus.end_y         <= '0;
    in_bus.segment_count <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      row = curve_table[r];
      offer_curve(row.cv);
      if (!row.typed) begin
        predict_curve_points(row.cv);
      end else if (row.cv.n != 0) begin
        queue_point(row.cv.sx, row.cv.sy, 1'b0);
        for (int i = 1; i < row.cv.n; i++)
          queue_point(row.mx, row.my, 1'b0);
        queue_point(row.cv.ex, row.cv.ey, 1'b1);
      end
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      gaps_on = ((k / 40) % 3) != 1;
      cv.sx  = rand_coord();
      cv.sy  = rand_coord();
      cv.c1x = rand_coord();
      cv.c1y = rand_coord();
      cv.c2x = rand_coord();
      cv.c2y = rand_coord();
      cv.ex  = rand_coord();
      cv.ey  = rand_coord();
      cv.n   = rand_count();
      offer_curve(cv);
      predict_curve_points(cv);
    end
    in_bus.valid <= 1'b0;
    gaps_on = 1'b1;

    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d curve words sent (directed and random), %0d point words checked,",
             n_curves, n_points);
    $display("%0d field errors; long output stall and idle-free stretches included",
             n_errors);
    if (n_errors == 0) begin
      $display("cubic_bezier_point_generator: match");
    end else begin
      $display("cubic_bezier_point_generator: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("%0t: timeout with %0d point words outstanding", $time, points_due.size());
    $display("cubic_bezier_point_generator: mismatch");
    $finish;
  end

endmodule
